### hw/rtl/font_glyph_rom_address_assert.svh
// ----------------------------------------------------------------------------
// font glyph rom address assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef FONT_GLYPH_ROM_ADDRESS_ASSERT_SVH
`define FONT_GLYPH_ROM_ADDRESS_ASSERT_SVH

// same-cycle implication
`define FGRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FGRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fgra_pkg.sv
// ----------------------------------------------------------------------------
// fgra_pkg
// shared types and constants of the font glyph rom address block
// ----------------------------------------------------------------------------
package fgra_pkg;

    localparam int TABLE_ENTRIES = 228;
    localparam int TBL_IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TBL_CNT_W     = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W = 24;

    localparam logic [7:0] BYTE_40 = 8'h40;
    localparam logic [7:0] BYTE_41 = 8'h41;
    localparam logic [7:0] BYTE_80 = 8'h80;
    localparam logic [7:0] BYTE_A1 = 8'hA1;
    localparam logic [7:0] BYTE_A8 = 8'hA8;
    localparam logic [7:0] BYTE_AA = 8'hAA;
    localparam logic [7:0] BYTE_B0 = 8'hB0;
    localparam logic [7:0] BYTE_F8 = 8'hF8;

    localparam logic [6:0] MULT_ONE = 7'd1;
    localparam logic [6:0] MULT_97  = 7'd97;
    localparam logic [6:0] MULT_96  = 7'd96;
    localparam logic [6:0] MULT_94  = 7'd94;

    localparam logic [ADDR_W-1:0] BASE_NARROW = 24'h0780B7;
    localparam logic [ADDR_W-1:0] BASE_REMAP  = 24'h047800;
    localparam logic [ADDR_W-1:0] BASE_LOWROW = 24'h03BD80;
    localparam logic [ADDR_W-1:0] BASE_SYMBOL = 24'h034E00;
    localparam logic [ADDR_W-1:0] BASE_ROW_AA = 24'h03DF40;
    localparam logic [ADDR_W-1:0] BASE_MAIN   = 24'h000000;
    localparam logic [ADDR_W-1:0] BASE_ROW_F8 = 24'h0425C0;

    localparam logic [ADDR_W-1:0] ROM_LOW  = 24'h800000;
    localparam logic [ADDR_W:0]   ROM_HIGH = 25'h0A00000;

    localparam logic [5:0] BYTES_NARROW = 6'd16;
    localparam logic [5:0] BYTES_WIDE   = 6'd32;

    typedef struct packed {
        logic [7:0] key_high;
        logic [7:0] key_low;
        logic [7:0] map_low;
        logic [7:0] map_high;
    } fgra_entry_t;

    typedef struct packed {
        logic [7:0]        hv;
        logic [7:0]        sub;
        logic [6:0]        mult;
        logic [7:0]        addend;
        logic [ADDR_W-1:0] base;
        logic              shift5;
    } fgra_op_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
    } fgra_step_t;

endpackage

### hw/rtl/font_glyph_rom_address.sv
// ----------------------------------------------------------------------------
// font_glyph_rom_address
// maps a character code to the rom address of its glyph bitmap
// ----------------------------------------------------------------------------
// A load beat (func 0) writes one remap table entry in the cycle it is taken,
// if entry_index lies within the table. A lookup beat (func 1) holds in_ready
// low until its result is in the output register. Every lookup passes the
// select, multiply, add and finish states; a searched double-byte code first
// reads the remap table through its single read port, one entry per cycle,
// and stops at the first match. The offset takes one pass through the shared
// multiply-add unit. A finished result waits in the output register while
// the next beat is taken.
module font_glyph_rom_address
    import fgra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [7:0]        entry_index,
    input  logic [7:0]        key_high,
    input  logic [7:0]        key_low,
    input  logic [7:0]        map_high,
    input  logic [7:0]        map_low,
    input  logic              glyph_kind,
    input  logic [7:0]        code_low,
    input  logic [7:0]        code_high,
    input  logic [7:0]        bank,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] glyph_address,
    output logic [5:0]        glyph_bytes,
    output logic [7:0]        final_low,
    output logic [7:0]        final_high,
    output logic              out_of_range
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEL,
        ST_MUL,
        ST_ADD,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        lo_reg, lo_next;
    logic [7:0]        hi_reg, hi_next;
    logic              kind_reg, kind_next;
    logic [7:0]        bank_reg, bank_next;
    logic              mapped_reg, mapped_next;
    logic [TBL_CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              chk_reg, chk_next;
    fgra_op_t          op_reg, op_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [5:0]        bytes_reg, bytes_next;
    logic [7:0]        flow_reg, flow_next;
    logic [7:0]        fhigh_reg, fhigh_next;
    logic              oor_reg, oor_next;

    logic              accept;
    logic              issue;
    logic              mem_we;
    fgra_entry_t       mem_wdata;
    fgra_entry_t       mem_rdata;
    fgra_step_t        step;
    logic [ADDR_W-1:0] offset;
    fgra_op_t          sel_op;
    logic [ADDR_W-1:0] addr_calc;
    logic [5:0]        bytes_calc;
    logic [ADDR_W:0]   addr_end;
    logic [7:0]        lo_adj;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == ST_SCAN) && (scan_cnt_reg < TBL_CNT_W'(TABLE_ENTRIES));

    assign mem_we    = accept && !func && ({1'b0, entry_index} < 9'(TABLE_ENTRIES));
    assign mem_wdata = '{key_high: key_high, key_low: key_low,
                         map_low: map_low, map_high: map_high};

    fgra_remap_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (entry_index[TBL_IDX_W-1:0]),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (scan_cnt_reg[TBL_IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    assign step.mul_en = (state_reg == ST_MUL);
    assign step.add_en = (state_reg == ST_ADD);

    fgra_mac u_mac (
        .clk    (clk),
        .op     (op_reg),
        .step   (step),
        .offset (offset)
    );

    // zone and position selection
    always_comb
    begin
        lo_adj = lo_reg - ((lo_reg >= BYTE_80) ? BYTE_41 : BYTE_40);
        sel_op = '{hv: hi_reg, sub: BYTE_A1, mult: MULT_94,
                   addend: lo_reg - BYTE_A1, base: BASE_SYMBOL, shift5: 1'b1};
        if (!kind_reg)
        begin
            sel_op = '{hv: lo_reg, sub: 8'h00, mult: MULT_ONE,
                       addend: 8'h00, base: BASE_NARROW, shift5: 1'b0};
        end
        else if ((hi_reg < BYTE_AA) &&
                 (mapped_reg || ((lo_reg < BYTE_A1) && (hi_reg < BYTE_A8))))
        begin
            sel_op = '{hv: hi_reg, sub: BYTE_A1, mult: MULT_97,
                       addend: lo_reg - BYTE_40, base: BASE_REMAP, shift5: 1'b1};
        end
        else if ((hi_reg < BYTE_AA) && (lo_reg < BYTE_A1))
        begin
            sel_op = '{hv: hi_reg, sub: BYTE_A8, mult: MULT_96,
                       addend: lo_adj, base: BASE_LOWROW, shift5: 1'b1};
        end
        else if (hi_reg < BYTE_AA)
        begin
            sel_op.sub  = BYTE_A1;
            sel_op.base = BASE_SYMBOL;
        end
        else if (hi_reg < BYTE_B0)
        begin
            sel_op.sub  = BYTE_AA;
            sel_op.base = BASE_ROW_AA;
        end
        else if (hi_reg < BYTE_F8)
        begin
            sel_op.sub  = BYTE_B0;
            sel_op.base = BASE_MAIN;
        end
        else
        begin
            sel_op.sub  = BYTE_F8;
            sel_op.base = BASE_ROW_F8;
        end
    end

    assign addr_calc  = {offset[23:16] + bank_reg, offset[15:0]};
    assign bytes_calc = kind_reg ? BYTES_WIDE : BYTES_NARROW;
    assign addr_end   = {1'b0, addr_calc} + (ADDR_W + 1)'(bytes_calc);

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        kind_next      = kind_reg;
        bank_next      = bank_reg;
        mapped_next    = mapped_reg;
        scan_cnt_next  = scan_cnt_reg;
        chk_next       = 1'b0;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        bytes_next     = bytes_reg;
        flow_next      = flow_reg;
        fhigh_next     = fhigh_reg;
        oor_next       = oor_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func)
                begin
                    lo_next       = code_low;
                    hi_next       = glyph_kind ? code_high : 8'h00;
                    kind_next     = glyph_kind;
                    bank_next     = bank;
                    mapped_next   = 1'b0;
                    scan_cnt_next = '0;
                    if (glyph_kind && ((code_high < BYTE_A1) ||
                        ((code_high >= BYTE_AA) && (code_low < BYTE_A1))))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_SEL;
                    end
                end
            end
            ST_SCAN:
            begin
                chk_next = issue;
                if (issue)
                begin
                    scan_cnt_next = scan_cnt_reg + TBL_CNT_W'(1);
                end
                if (chk_reg && (mem_rdata.key_high == hi_reg) &&
                    (mem_rdata.key_low == lo_reg))
                begin
                    lo_next     = mem_rdata.map_low;
                    hi_next     = mem_rdata.map_high;
                    mapped_next = 1'b1;
                    chk_next    = 1'b0;
                    state_next  = ST_SEL;
                end
                else if (!issue && !chk_reg)
                begin
                    lo_next    = BYTE_A1;
                    hi_next    = BYTE_A1;
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                op_next    = sel_op;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = addr_calc;
                    bytes_next     = bytes_calc;
                    flow_next      = lo_reg;
                    fhigh_next     = hi_reg;
                    oor_next       = (addr_calc < ROM_LOW) || (addr_end > ROM_HIGH);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        kind_reg     <= kind_next;
        bank_reg     <= bank_next;
        mapped_reg   <= mapped_next;
        scan_cnt_reg <= scan_cnt_next;
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        bytes_reg    <= bytes_next;
        flow_reg     <= flow_next;
        fhigh_reg    <= fhigh_next;
        oor_reg      <= oor_next;
    end

    assign out_valid     = out_valid_reg;
    assign glyph_address = addr_reg;
    assign glyph_bytes   = bytes_reg;
    assign final_low     = flow_reg;
    assign final_high    = fhigh_reg;
    assign out_of_range  = oor_reg;

endmodule

### hw/rtl/fgra_remap_mem.sv
// ----------------------------------------------------------------------------
// fgra_remap_mem
// remap table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module fgra_remap_mem
    import fgra_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [TBL_IDX_W-1:0] waddr,
    input  fgra_entry_t          wdata,
    input  logic                 re,
    input  logic [TBL_IDX_W-1:0] raddr,
    output fgra_entry_t          rdata
);

    fgra_entry_t mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/fgra_mac.sv
// ----------------------------------------------------------------------------
// fgra_mac
// shared multiply-add unit: base + (((hv - sub) * mult + addend) << 4 or 5)
// ----------------------------------------------------------------------------
module fgra_mac
    import fgra_pkg::*;
(
    input  logic              clk,
    input  fgra_op_t          op,
    input  fgra_step_t        step,
    output logic [ADDR_W-1:0] offset
);

    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] prod_full;
    logic [ADDR_W-1:0] prod_reg;
    logic [ADDR_W-1:0] sum;
    logic [ADDR_W-1:0] offset_next;
    logic [ADDR_W-1:0] offset_reg;

    assign diff      = ADDR_W'(op.hv) - ADDR_W'(op.sub);
    assign prod_full = diff * ADDR_W'(op.mult);
    assign sum       = prod_reg + ADDR_W'(op.addend);
    assign offset_next = op.base + (op.shift5 ? (sum << 5) : (sum << 4));

    always_ff @(posedge clk)
    begin
        if (step.mul_en)
        begin
            prod_reg <= prod_full;
        end
        if (step.add_en)
        begin
            offset_reg <= offset_next;
        end
    end

    assign offset = offset_reg;

endmodule

### hw/rtl/fgra_checker.sv
// ----------------------------------------------------------------------------
// fgra_checker
// port-level assertions for font_glyph_rom_address, attached by bind
// ----------------------------------------------------------------------------
`include "font_glyph_rom_address_assert.svh"

module fgra_checker
    import fgra_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              func,
    input logic              glyph_kind,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ADDR_W-1:0] glyph_address,
    input logic [5:0]        glyph_bytes,
    input logic [7:0]        final_high,
    input logic              out_of_range
);

    logic [ADDR_W:0] addr_end;
    logic            range_bad;
    logic            out_hold;

    assign addr_end  = {1'b0, glyph_address} + (ADDR_W + 1)'(glyph_bytes);
    assign range_bad = (glyph_address < ROM_LOW) || (addr_end > ROM_HIGH);
    assign out_hold  = out_valid && !out_ready;

    `FGRA_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(glyph_address), "result beat dropped or changed while stalled")
    `FGRA_ASSERT_NOW(a_bytes, out_valid, (glyph_bytes == BYTES_NARROW) || (glyph_bytes == BYTES_WIDE), "glyph size not 16 or 32")
    `FGRA_ASSERT_NOW(a_narrow_high, out_valid && (glyph_bytes == BYTES_NARROW), final_high == 8'h00, "single-byte result with nonzero high byte")
    `FGRA_ASSERT_NOW(a_range, out_valid, out_of_range == range_bad, "range flag disagrees with address")
    `FGRA_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && func && !glyph_kind, !in_ready, "lookup beat did not make the block busy")

endmodule

bind font_glyph_rom_address fgra_checker u_fgra_checker (.*);

### test/font_glyph_rom_address_tb.sv
// ----------------------------------------------------------------------------
// font_glyph_rom_address_tb
// self-checking bench for the glyph rom address block
// ----------------------------------------------------------------------------
// The remap table is filled first. A short directed set then covers the code
// zones, the extreme bytes and banks, table hits and misses, slots past the
// table and replacement bytes that wrap the zone math. About seventeen hundred
// random beats follow, mostly double-byte lookups, many of known table keys. An
// in-order predictor works out each lookup result when the input beat is
// taken, and every output beat is checked against the oldest prediction.
// Both sides idle at random. The receiver also holds off once for a long
// stretch, and the sender sometimes waits for all results to drain.
// ----------------------------------------------------------------------------
module font_glyph_rom_address_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fgra_pkg::*;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;
    localparam logic KIND_NARROW = 1'b0;
    localparam logic KIND_WIDE   = 1'b1;

    localparam int RANDOM_BEATS  = 1700;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 240;
    localparam int HOLD_CYCLES   = 600;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic       func;
        logic [7:0] entry_index;
        logic [7:0] key_high;
        logic [7:0] key_low;
        logic [7:0] map_high;
        logic [7:0] map_low;
        logic       glyph_kind;
        logic [7:0] code_low;
        logic [7:0] code_high;
        logic [7:0] bank;
        bit         hold_for_drain;
    } glyph_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] glyph_address;
        logic [5:0]        glyph_bytes;
        logic [7:0]        final_low;
        logic [7:0]        final_high;
        logic              out_of_range;
    } glyph_result_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              func         = 1'b0;
    logic [7:0]        entry_index  = 8'd0;
    logic [7:0]        key_high     = 8'd0;
    logic [7:0]        key_low      = 8'd0;
    logic [7:0]        map_high     = 8'd0;
    logic [7:0]        map_low      = 8'd0;
    logic              glyph_kind   = 1'b0;
    logic [7:0]        code_low     = 8'd0;
    logic [7:0]        code_high    = 8'd0;
    logic [7:0]        bank         = 8'd0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [ADDR_W-1:0] glyph_address;
    logic [5:0]        glyph_bytes;
    logic [7:0]        final_low;
    logic [7:0]        final_high;
    logic              out_of_range;

    glyph_beat_t   glyph_beats[$];
    glyph_result_t expected_results[$];
    fgra_entry_t   remap_copy[TABLE_ENTRIES];
    logic [7:0]    gen_key_high[TABLE_ENTRIES];
    logic [7:0]    gen_key_low[TABLE_ENTRIES];

    bit drain_next      = 1'b0;
    int total_beats     = 0;
    int beats_taken     = 0;
    int results_due     = 0;
    int stall_at        = 0;
    int hold_left       = 0;
    bit hold_fired      = 1'b0;
    int cycle_count     = 0;
    int failures        = 0;
    int loads_seen      = 0;
    int ignored_loads   = 0;
    int narrow_lookups  = 0;
    int wide_lookups    = 0;
    int searched_hits   = 0;
    int searched_misses = 0;
    int outside_window  = 0;

    font_glyph_rom_address DUT (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    // expected result of one lookup against the current table copy
    function automatic glyph_result_t lookup_glyph(logic kind, logic [7:0] lo_in,
                                                   logic [7:0] hi_in, logic [7:0] bank_in);
        glyph_result_t res;
        bit [31:0]     l;
        bit [31:0]     h;
        bit [31:0]     off;
        bit [31:0]     idx;
        bit [31:0]     addr;
        bit [31:0]     nbytes;
        bit            remapped;
        int            slot;
        int            i;
        l        = lo_in;
        h        = 32'd0;
        remapped = 1'b0;
        slot     = -1;
        if (kind == KIND_NARROW)
        begin
            nbytes = 32'd16;
            off    = 32'h780b7 + l * 32'd16;
        end
        else
        begin
            h      = hi_in;
            nbytes = 32'd32;
            if (h < 32'ha1 || (h >= 32'haa && l < 32'ha1))
            begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (slot < 0 && remap_copy[i].key_high == h[7:0]
                        && remap_copy[i].key_low == l[7:0])
                        slot = i;
                if (slot < 0)
                begin
                    l = 32'ha1;
                    h = 32'ha1;
                    searched_misses++;
                end
                else
                begin
                    l        = remap_copy[slot].map_low;
                    h        = remap_copy[slot].map_high;
                    remapped = 1'b1;
                    searched_hits++;
                end
            end
            if ((remapped && h < 32'haa) || (h < 32'ha8 && l < 32'ha1))
                off = 32'h47800 + ((h - 32'ha1) * 32'd97 + ((l - 32'h40) & 32'hff)) * 32'd32;
            else if (h < 32'haa && l < 32'ha1)
            begin
                idx = (h - 32'ha8) * 32'd96
                    + ((l - (l >= 32'h80 ? 32'h41 : 32'h40)) & 32'hff);
                off = 32'h3bd80 + idx * 32'd32;
            end
            else
            begin
                idx = (l - 32'ha1) & 32'hff;
                if (h < 32'haa)
                    off = 32'h34e00 + ((h - 32'ha1) * 32'd94 + idx) * 32'd32;
                else if (h < 32'hb0)
                    off = 32'h3df40 + ((h - 32'haa) * 32'd94 + idx) * 32'd32;
                else if (h < 32'hf8)
                    off = ((h - 32'hb0) * 32'd94 + idx) * 32'd32;
                else
                    off = 32'h425c0 + ((h - 32'hf8) * 32'd94 + idx) * 32'd32;
            end
        end
        addr = {8'd0, off[23:16] + bank_in, off[15:0]};
        res.glyph_address = addr[ADDR_W-1:0];
        res.glyph_bytes   = nbytes[5:0];
        res.final_low     = l[7:0];
        res.final_high    = h[7:0];
        res.out_of_range  = (addr < 32'h800000) || (addr + nbytes > 32'ha00000);
        return res;
    endfunction

    function automatic int idle_pct(bit sink);
        int phase;
        phase = (total_beats == 0) ? 0 : beats_taken * 3 / total_beats;
        if (phase == 0)
            return sink ? 48 : 23;
        if (phase == 1)
            return sink ? 23 : 48;
        return 0;
    endfunction

    function automatic logic [7:0] pick_bank();
        if ($urandom_range(99) < 60)
            return 8'($urandom_range(8'h74, 8'h9f));
        return 8'($urandom);
    endfunction

    task automatic queue_beat(glyph_beat_t b);
        b.hold_for_drain = drain_next;
        drain_next       = 1'b0;
        if (b.func == FUNC_LOAD && b.entry_index < TABLE_ENTRIES)
        begin
            gen_key_high[b.entry_index] = b.key_high;
            gen_key_low[b.entry_index]  = b.key_low;
        end
        glyph_beats.push_back(b);
    endtask

    task automatic queue_load(int slot, logic [7:0] kh, logic [7:0] kl,
                              logic [7:0] mh, logic [7:0] ml);
        glyph_beat_t b;
        b.func        = FUNC_LOAD;
        b.entry_index = slot[7:0];
        b.key_high    = kh;
        b.key_low     = kl;
        b.map_high    = mh;
        b.map_low     = ml;
        b.glyph_kind  = 1'($urandom);
        b.code_low    = 8'($urandom);
        b.code_high   = 8'($urandom);
        b.bank        = 8'($urandom);
        queue_beat(b);
    endtask

    task automatic queue_lookup(logic kind, logic [7:0] lo, logic [7:0] hi, logic [7:0] bk);
        glyph_beat_t b;
        b.func        = FUNC_LOOKUP;
        b.entry_index = 8'($urandom);
        b.key_high    = 8'($urandom);
        b.key_low     = 8'($urandom);
        b.map_high    = 8'($urandom);
        b.map_low     = 8'($urandom);
        b.glyph_kind  = kind;
        b.code_low    = lo;
        b.code_high   = hi;
        b.bank        = bk;
        queue_beat(b);
    endtask

    // a key pair in the searched region, sometimes a copy of an earlier slot
    task automatic new_key(int filled, output logic [7:0] kh, output logic [7:0] kl);
        int src;
        if (filled > 0 && $urandom_range(7) == 0)
        begin
            src = $urandom_range(filled - 1);
            kh  = gen_key_high[src];
            kl  = gen_key_low[src];
        end
        else if ($urandom_range(1) == 0)
        begin
            kh = 8'($urandom_range(8'ha0));
            kl = 8'($urandom);
        end
        else
        begin
            kh = 8'($urandom_range(8'haa, 8'hff));
            kl = 8'($urandom_range(8'ha0));
        end
    endtask

    task automatic replacement(output logic [7:0] mh, output logic [7:0] ml);
        if ($urandom_range(3) != 0)
        begin
            mh = 8'($urandom_range(8'ha1, 8'hfe));
            ml = 8'($urandom_range(8'h40, 8'hfe));
        end
        else
        begin
            mh = 8'($urandom);
            ml = 8'($urandom);
        end
    endtask

    task automatic note_failure(string what, glyph_result_t want, glyph_result_t got);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("%s: expected addr %h bytes %0d low %h high %h oor %b",
                     what, want.glyph_address, want.glyph_bytes, want.final_low,
                     want.final_high, want.out_of_range);
            $display("    got addr %h bytes %0d low %h high %h oor %b",
                     got.glyph_address, got.glyph_bytes, got.final_low,
                     got.final_high, got.out_of_range);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : feed
        glyph_beat_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (glyph_beats.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)
                && (!glyph_beats[0].hold_for_drain || (!in_valid && results_due == 0)))
            begin
                nxt = glyph_beats.pop_front();
                func        <= nxt.func;
                entry_index <= nxt.entry_index;
                key_high    <= nxt.key_high;
                key_low     <= nxt.key_low;
                map_high    <= nxt.map_high;
                map_low     <= nxt.map_low;
                glyph_kind  <= nxt.glyph_kind;
                code_low    <= nxt.code_low;
                code_high   <= nxt.code_high;
                bank        <= nxt.bank;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off, once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end
        else if (!hold_fired && stall_at != 0 && beats_taken >= stall_at)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
    end

    // prediction on input beats, checking on output beats
    always @(posedge clk)
    begin : watch
        glyph_result_t want;
        glyph_result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                beats_taken <= beats_taken + 1;
                if (func == FUNC_LOAD)
                begin
                    loads_seen++;
                    if (entry_index < TABLE_ENTRIES)
                        remap_copy[entry_index] = {key_high, key_low, map_low, map_high};
                    else
                        ignored_loads++;
                end
                else
                begin
                    if (glyph_kind == KIND_NARROW)
                        narrow_lookups++;
                    else
                        wide_lookups++;
                    expected_results.push_back(lookup_glyph(glyph_kind, code_low,
                                                            code_high, bank));
                end
            end
            if (out_valid && out_ready)
            begin
                got = {glyph_address, glyph_bytes, final_low, final_high, out_of_range};
                if (got.out_of_range)
                    outside_window++;
                if (expected_results.size() == 0)
                    note_failure("unexpected result beat", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        note_failure("result mismatch", want, got);
                end
            end
            results_due <= expected_results.size();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d beats taken, %0d results due",
                     cycle_count, beats_taken, total_beats, results_due);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0] kh;
        logic [7:0] kl;
        logic [7:0] mh;
        logic [7:0] ml;
        int         i;
        int         n;
        int         slot;
        int         roll;
        int         pick;
        bit         found;

        // fill every slot before any lookup
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            new_key(i, kh, kl);
            replacement(mh, ml);
            queue_load(i, kh, kl, mh, ml);
        end

        // slots past the table are ignored
        drain_next = 1'b1;
        queue_load(TABLE_ENTRIES, 8'h12, 8'h34, 8'hb5, 8'hc6);
        queue_load(255, 8'h00, 8'hff, 8'hff, 8'h00);
        queue_lookup(KIND_WIDE, 8'h34, 8'h12, 8'h80);

        // single-byte extremes and banks around the rom window
        queue_lookup(KIND_NARROW, 8'h00, 8'hff, 8'h00);
        queue_lookup(KIND_NARROW, 8'hff, 8'h00, 8'hff);
        queue_lookup(KIND_NARROW, 8'h80, 8'h5a, 8'h79);
        queue_lookup(KIND_NARROW, 8'h01, 8'ha5, 8'h99);

        // unsearched double-byte zones
        queue_lookup(KIND_WIDE, 8'h40, 8'ha1, 8'h80);
        queue_lookup(KIND_WIDE, 8'h40, 8'ha8, 8'h80);
        queue_lookup(KIND_WIDE, 8'h7f, 8'ha9, 8'h80);
        queue_lookup(KIND_WIDE, 8'h80, 8'ha9, 8'h80);
        queue_lookup(KIND_WIDE, 8'ha1, 8'ha1, 8'h80);
        queue_lookup(KIND_WIDE, 8'hfe, 8'ha9, 8'h80);
        queue_lookup(KIND_WIDE, 8'ha1, 8'haa, 8'h80);
        queue_lookup(KIND_WIDE, 8'hff, 8'haf, 8'h80);
        queue_lookup(KIND_WIDE, 8'ha1, 8'hb0, 8'h80);
        queue_lookup(KIND_WIDE, 8'ha1, 8'hb0, 8'h7f);
        queue_lookup(KIND_WIDE, 8'hd6, 8'hdb, 8'h9e);
        queue_lookup(KIND_WIDE, 8'hd6, 8'hdb, 8'h9f);
        queue_lookup(KIND_WIDE, 8'hfe, 8'hf7, 8'h80);
        queue_lookup(KIND_WIDE, 8'ha1, 8'hf8, 8'h80);
        queue_lookup(KIND_WIDE, 8'hff, 8'hff, 8'h80);

        // table hits at both ends, a miss, and a replacement that wraps
        queue_lookup(KIND_WIDE, gen_key_low[0], gen_key_high[0], 8'h80);
        queue_lookup(KIND_WIDE, gen_key_low[TABLE_ENTRIES-1],
                     gen_key_high[TABLE_ENTRIES-1], 8'h85);
        do
        begin
            new_key(0, kh, kl);
            found = 1'b0;
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (gen_key_high[i] == kh && gen_key_low[i] == kl)
                    found = 1'b1;
        end
        while (found);
        queue_lookup(KIND_WIDE, kl, kh, 8'h80);
        queue_load(0, gen_key_high[0], gen_key_low[0], 8'h00, 8'h00);
        queue_lookup(KIND_WIDE, gen_key_low[0], gen_key_high[0], 8'h80);

        stall_at = glyph_beats.size() + 400;

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 300 == 150)
                drain_next = 1'b1;
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                slot = ($urandom_range(7) == 0) ? $urandom_range(TABLE_ENTRIES, 255)
                                                : $urandom_range(TABLE_ENTRIES - 1);
                new_key(TABLE_ENTRIES, kh, kl);
                replacement(mh, ml);
                queue_load(slot, kh, kl, mh, ml);
            end
            else if (roll < 32)
                queue_lookup(KIND_NARROW, 8'($urandom), 8'($urandom), pick_bank());
            else
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    slot = $urandom_range(TABLE_ENTRIES - 1);
                    kh   = gen_key_high[slot];
                    kl   = gen_key_low[slot];
                end
                else if (pick < 70)
                    new_key(0, kh, kl);
                else
                begin
                    kh = 8'($urandom);
                    kl = 8'($urandom);
                end
                queue_lookup(KIND_WIDE, kl, kh, pick_bank());
            end
        end
        total_beats = glyph_beats.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_taken < total_beats || results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d beats: %0d table loads (%0d past the table), %0d single-byte and %0d %s",
                 beats_taken, loads_seen, ignored_loads, narrow_lookups, wide_lookups,
                 "double-byte lookups");
        $display("table searches: %0d hits, %0d misses; %0d results outside the rom window",
                 searched_hits, searched_misses, outside_window);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
